// File: hdl/dag_path_counter_core_defines.svh
// assertion macros for the path counter core
// no dependencies; expects clk and rst_n in the including scope
`ifndef DAG_PATH_COUNTER_CORE_DEFINES_SVH
`define DAG_PATH_COUNTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define DPC_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dpc check failed");
`define DPC_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dpc check failed");
`else
`define DPC_ASSERT_ALWAYS(name, cond)
`define DPC_ASSERT_NEXT(name, pre, post)
`endif
`endif

// File: hdl/dpc_pkg.sv
// types, constants and state codes for the path counter core
// no dependencies
package dpc_pkg;

    localparam int MAX_VERTICES   = 1024;
    localparam int MAX_NEIGHBOURS = 32;
    localparam int VTX_W          = $clog2(MAX_VERTICES);
    localparam int NB_W           = $clog2(MAX_NEIGHBOURS);
    localparam int CNT_W          = NB_W + 1;
    localparam int LIM_W          = VTX_W + 1;
    localparam int TBL_AW         = VTX_W + NB_W;
    localparam int SUM_W          = 64;

    localparam logic [1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [1:0] OP_QUERY    = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DEPTH    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(MAX_VERTICES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NEIGHBOURS);

    typedef struct packed {
        logic [1:0]       op;
        logic [VTX_W-1:0] from_vertex;
        logic [VTX_W-1:0] to_vertex;
    } in_item_t;

    typedef struct packed {
        logic [SUM_W-1:0] path_count;
        logic [1:0]       status;
    } out_item_t;

    typedef struct packed {
        logic [VTX_W-1:0] vtx;
        logic [CNT_W-1:0] nxt;
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum;
    } frame_t;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] value;
    } memo_t;

    typedef enum logic [3:0] {
        S_CLR_CNT,
        S_IDLE,
        S_EDGE,
        S_CLR_MEMO,
        S_ISSUE,
        S_MEMO_WAIT,
        S_CNT_WAIT,
        S_STEP,
        S_NB_WAIT,
        S_POP_WAIT,
        S_FINISH
    } state_t;

endpackage

// File: hdl/dpc_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module dpc_ram #(
    parameter int W  = 8,
    parameter int AW = 10
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem [(1 << AW)];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hdl/dpc_engine.sv
// walk sequencer: edge loads, graph clears and memoized depth-first path counts
// depends on dpc_pkg, dpc_ram and dag_path_counter_core_defines.svh
`include "dag_path_counter_core_defines.svh"

module dpc_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  dpc_pkg::in_item_t                in_data,
    input  logic [dpc_pkg::LIM_W-1:0]        count_limit,
    output logic                             res_valid,
    input  logic                             res_ready,
    output dpc_pkg::out_item_t               res_data
);

    dpc_pkg::state_t state_reg, state_next;
    logic [dpc_pkg::VTX_W-1:0] a_reg, a_next, b_reg, b_next, t_reg, t_next;
    logic [dpc_pkg::LIM_W-1:0] limit_reg, limit_next, clr_reg, clr_next, sp_reg, sp_next;
    dpc_pkg::frame_t top_reg, top_next;
    logic [dpc_pkg::SUM_W-1:0] val_reg, val_next;
    logic depth_reg, depth_next, ovf_reg, ovf_next, oor_reg, oor_next;

    logic tbl_we;
    logic [dpc_pkg::TBL_AW-1:0] tbl_waddr, tbl_raddr;
    logic [dpc_pkg::VTX_W-1:0] tbl_wdata, tbl_rdata;
    logic cnt_we;
    logic [dpc_pkg::VTX_W-1:0] cnt_waddr, cnt_raddr;
    logic [dpc_pkg::CNT_W-1:0] cnt_wdata, cnt_rdata;
    logic memo_we;
    logic [dpc_pkg::VTX_W-1:0] memo_waddr, memo_raddr;
    dpc_pkg::memo_t memo_wdata, memo_rdata;
    logic stk_we;
    logic [dpc_pkg::VTX_W-1:0] stk_waddr, stk_raddr;
    dpc_pkg::frame_t stk_wdata, stk_rdata;

    logic accept;
    logic [dpc_pkg::LIM_W-1:0] sp_m1, sp_m2;

    dpc_ram #(.W(dpc_pkg::VTX_W), .AW(dpc_pkg::TBL_AW)) u_tbl (
        .clk(clk), .wr_en(tbl_we), .wr_addr(tbl_waddr), .wr_data(tbl_wdata),
        .rd_addr(tbl_raddr), .rd_data(tbl_rdata)
    );
    dpc_ram #(.W(dpc_pkg::CNT_W), .AW(dpc_pkg::VTX_W)) u_cnt (
        .clk(clk), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
        .rd_addr(cnt_raddr), .rd_data(cnt_rdata)
    );
    dpc_ram #(.W($bits(dpc_pkg::memo_t)), .AW(dpc_pkg::VTX_W)) u_memo (
        .clk(clk), .wr_en(memo_we), .wr_addr(memo_waddr), .wr_data(memo_wdata),
        .rd_addr(memo_raddr), .rd_data(memo_rdata)
    );
    dpc_ram #(.W($bits(dpc_pkg::frame_t)), .AW(dpc_pkg::VTX_W)) u_stk (
        .clk(clk), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
        .rd_addr(stk_raddr), .rd_data(stk_rdata)
    );

    assign in_stall = (state_reg != dpc_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign sp_m1    = sp_reg - dpc_pkg::LIM_W'(1);
    assign sp_m2    = sp_reg - dpc_pkg::LIM_W'(2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dpc_pkg::S_CLR_CNT;
            clr_reg   <= '0;
            sp_reg    <= '0;
            limit_reg <= dpc_pkg::LIM_MAX;
            depth_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            oor_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            sp_reg    <= sp_next;
            limit_reg <= limit_next;
            depth_reg <= depth_next;
            ovf_reg   <= ovf_next;
            oor_reg   <= oor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        t_reg   <= t_next;
        top_reg <= top_next;
        val_reg <= val_next;
    end

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        t_next     = t_reg;
        limit_next = limit_reg;
        clr_next   = clr_reg;
        sp_next    = sp_reg;
        top_next   = top_reg;
        val_next   = val_reg;
        depth_next = depth_reg;
        ovf_next   = ovf_reg;
        oor_next   = oor_reg;
        tbl_we     = 1'b0;
        tbl_waddr  = {a_reg, cnt_rdata[dpc_pkg::NB_W-1:0]};
        tbl_wdata  = b_reg;
        tbl_raddr  = {top_reg.vtx, top_reg.nxt[dpc_pkg::NB_W-1:0]};
        cnt_we     = 1'b0;
        cnt_waddr  = a_reg;
        cnt_wdata  = cnt_rdata + dpc_pkg::CNT_W'(1);
        cnt_raddr  = in_data.from_vertex;
        memo_we    = 1'b0;
        memo_waddr = top_reg.vtx;
        memo_wdata = '{valid: 1'b1, value: top_reg.sum};
        memo_raddr = t_reg;
        stk_we     = 1'b0;
        stk_waddr  = sp_m1[dpc_pkg::VTX_W-1:0];
        stk_wdata  = top_reg;
        stk_raddr  = sp_m2[dpc_pkg::VTX_W-1:0];
        res_valid  = 1'b0;
        res_data.path_count = val_reg;
        res_data.status = oor_reg ? dpc_pkg::ST_RANGE
                        : depth_reg ? dpc_pkg::ST_DEPTH
                        : ovf_reg ? dpc_pkg::ST_OVERFLOW : dpc_pkg::ST_OK;
        case (state_reg)
            dpc_pkg::S_CLR_CNT:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg[dpc_pkg::VTX_W-1:0];
                cnt_wdata = '0;
                clr_next  = clr_reg + dpc_pkg::LIM_W'(1);
                if (clr_reg == dpc_pkg::LIM_MAX - dpc_pkg::LIM_W'(1))
                begin
                    state_next = dpc_pkg::S_IDLE;
                end
            end
            dpc_pkg::S_IDLE:
            begin
                a_next = in_data.from_vertex;
                b_next = in_data.to_vertex;
                if (accept)
                begin
                    case (in_data.op)
                        dpc_pkg::OP_ADD_EDGE:
                        begin
                            if ({1'b0, in_data.from_vertex} < count_limit
                                && {1'b0, in_data.to_vertex} < count_limit)
                            begin
                                state_next = dpc_pkg::S_EDGE;
                            end
                        end
                        dpc_pkg::OP_CLEAR:
                        begin
                            clr_next   = '0;
                            ovf_next   = 1'b0;
                            state_next = dpc_pkg::S_CLR_CNT;
                        end
                        dpc_pkg::OP_QUERY:
                        begin
                            limit_next = count_limit;
                            depth_next = 1'b0;
                            clr_next   = '0;
                            sp_next    = '0;
                            val_next   = '0;
                            if ({1'b0, in_data.from_vertex} < count_limit
                                && {1'b0, in_data.to_vertex} < count_limit)
                            begin
                                oor_next   = 1'b0;
                                state_next = dpc_pkg::S_CLR_MEMO;
                            end
                            else
                            begin
                                oor_next   = 1'b1;
                                state_next = dpc_pkg::S_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = dpc_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            dpc_pkg::S_EDGE:
            begin
                if (cnt_rdata >= dpc_pkg::CNT_MAX)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    tbl_we = 1'b1;
                    cnt_we = 1'b1;
                end
                state_next = dpc_pkg::S_IDLE;
            end
            dpc_pkg::S_CLR_MEMO:
            begin
                memo_we    = 1'b1;
                memo_waddr = clr_reg[dpc_pkg::VTX_W-1:0];
                memo_wdata = '0;
                clr_next   = clr_reg + dpc_pkg::LIM_W'(1);
                t_next     = a_reg;
                if (clr_reg == limit_reg - dpc_pkg::LIM_W'(1))
                begin
                    state_next = dpc_pkg::S_ISSUE;
                end
            end
            dpc_pkg::S_ISSUE:
            begin
                memo_raddr = t_reg;
                state_next = dpc_pkg::S_MEMO_WAIT;
            end
            dpc_pkg::S_MEMO_WAIT:
            begin
                cnt_raddr = t_reg;
                if (memo_rdata.valid || t_reg == b_reg)
                begin
                    if (!memo_rdata.valid)
                    begin
                        memo_we    = 1'b1;
                        memo_waddr = t_reg;
                        memo_wdata = '{valid: 1'b1, value: dpc_pkg::SUM_W'(1)};
                    end
                    if (sp_reg == '0)
                    begin
                        val_next   = memo_rdata.valid ? memo_rdata.value
                                                      : dpc_pkg::SUM_W'(1);
                        state_next = dpc_pkg::S_FINISH;
                    end
                    else
                    begin
                        top_next.sum = top_reg.sum + (memo_rdata.valid ? memo_rdata.value
                                                      : dpc_pkg::SUM_W'(1));
                        state_next   = dpc_pkg::S_STEP;
                    end
                end
                else
                begin
                    stk_we       = (sp_reg != '0);
                    top_next.vtx = t_reg;
                    top_next.nxt = '0;
                    top_next.sum = '0;
                    sp_next      = sp_reg + dpc_pkg::LIM_W'(1);
                    state_next   = dpc_pkg::S_CNT_WAIT;
                end
            end
            dpc_pkg::S_CNT_WAIT:
            begin
                top_next.cnt = cnt_rdata;
                state_next   = dpc_pkg::S_STEP;
            end
            dpc_pkg::S_STEP:
            begin
                if (top_reg.nxt < top_reg.cnt)
                begin
                    state_next = dpc_pkg::S_NB_WAIT;
                end
                else
                begin
                    memo_we  = 1'b1;
                    val_next = top_reg.sum;
                    sp_next  = sp_m1;
                    if (sp_reg == dpc_pkg::LIM_W'(1))
                    begin
                        state_next = dpc_pkg::S_FINISH;
                    end
                    else
                    begin
                        state_next = dpc_pkg::S_POP_WAIT;
                    end
                end
            end
            dpc_pkg::S_NB_WAIT:
            begin
                top_next.nxt = top_reg.nxt + dpc_pkg::CNT_W'(1);
                t_next       = tbl_rdata;
                memo_raddr   = tbl_rdata;
                if (sp_reg >= limit_reg)
                begin
                    depth_next = 1'b1;
                    state_next = dpc_pkg::S_STEP;
                end
                else if ({1'b0, tbl_rdata} >= limit_reg)
                begin
                    state_next = dpc_pkg::S_STEP;
                end
                else
                begin
                    state_next = dpc_pkg::S_MEMO_WAIT;
                end
            end
            dpc_pkg::S_POP_WAIT:
            begin
                top_next     = stk_rdata;
                top_next.sum = stk_rdata.sum + val_reg;
                state_next   = dpc_pkg::S_STEP;
            end
            dpc_pkg::S_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = dpc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dpc_pkg::S_IDLE;
            end
        endcase
    end

    `DPC_ASSERT_ALWAYS(a_sp_in_limit, sp_reg <= limit_reg)
    `DPC_ASSERT_NEXT(a_finish_leaves, res_valid && res_ready, state_reg == dpc_pkg::S_IDLE)
    `DPC_ASSERT_NEXT(a_edge_two_cycles, state_reg == dpc_pkg::S_EDGE,
        state_reg == dpc_pkg::S_IDLE)
    `DPC_ASSERT_ALWAYS(a_top_cnt_bound,
        state_reg != dpc_pkg::S_STEP || top_reg.cnt <= dpc_pkg::CNT_MAX)

endmodule

// File: hdl/dag_path_counter_core.sv
// path counter core: config register, walk sequencer and result register
// Edge load: S_EDGE then back to idle; clear graph: count memory sweep.
// Query: memo sweep over the live vertices, then the depth-first walk, paced by the one
// read port of each memory; one item at a time.
// Reset: async active low; a sweep of the whole count memory runs first with in_stall high.
module dag_path_counter_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  dpc_pkg::in_item_t     in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output dpc_pkg::out_item_t    out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [10:0]           cfg_data
);

    logic [10:0] vertex_count_reg;
    logic [dpc_pkg::LIM_W-1:0] count_limit;
    logic res_valid, res_ready, out_valid_reg;
    dpc_pkg::out_item_t res_data, out_data_reg;

    assign cfg_ready   = 1'b1;
    assign count_limit = (vertex_count_reg > 11'(dpc_pkg::MAX_VERTICES))
                       ? dpc_pkg::LIM_MAX : dpc_pkg::LIM_W'(vertex_count_reg);
    assign res_ready   = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= 11'd1024;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                vertex_count_reg <= cfg_data;
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    dpc_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .count_limit(count_limit),
        .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data)
    );

endmodule

// File: test/dag_path_counter_core_test.sv
// self-checking bench for dag_path_counter_core: edge loads, clears and path queries
// checked beat by beat against a memoized depth-first path count predictor
// depends on dpc_pkg and the core
module dag_path_counter_core_test;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 1300;

    typedef struct {
        logic [1:0] op;
        int         src;
        int         dst;
        bit         known;
        logic [63:0] cnt;
        logic [1:0] st;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    dpc_pkg::in_item_t  in_data;
    logic        out_valid;
    logic        out_stall;
    dpc_pkg::out_item_t out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;

    dag_path_counter_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [dpc_pkg::VTX_W-1:0] adj [dpc_pkg::MAX_VERTICES][dpc_pkg::MAX_NEIGHBOURS];
    int unsigned      adj_len [dpc_pkg::MAX_VERTICES];
    logic [63:0]      memo_cnt [dpc_pkg::MAX_VERTICES];
    bit               memo_set [dpc_pkg::MAX_VERTICES];
    int unsigned      frm_vtx [dpc_pkg::MAX_VERTICES];
    int unsigned      frm_nxt [dpc_pkg::MAX_VERTICES];
    logic [63:0]      frm_sum [dpc_pkg::MAX_VERTICES];
    int unsigned      depth_sp;
    bit               depth_flag;
    bit               dropped_edge;
    logic [10:0]      vtx_count;

    dpc_pkg::out_item_t pending_counts[$];
    int        errors;
    int        cycles;
    bit        no_idle;
    bit        in_held;

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned live_count();
        return (vtx_count > dpc_pkg::MAX_VERTICES) ? dpc_pkg::MAX_VERTICES : vtx_count;
    endfunction

    function automatic bit visit_vertex(int unsigned v, int unsigned depth, int unsigned lim,
                                        int unsigned goal, output logic [63:0] val);
        val = 64'd0;
        if (depth >= lim) begin
            depth_flag = 1'b1;
            return 1'b1;
        end
        if (v >= lim)
            return 1'b1;
        if (memo_set[v]) begin
            val = memo_cnt[v];
            return 1'b1;
        end
        if (v == goal) begin
            memo_cnt[v] = 64'd1;
            memo_set[v] = 1'b1;
            val = 64'd1;
            return 1'b1;
        end
        frm_vtx[depth_sp] = v;
        frm_nxt[depth_sp] = 0;
        frm_sum[depth_sp] = 64'd0;
        depth_sp++;
        return 1'b0;
    endfunction

    function automatic logic [63:0] count_paths(int unsigned start, int unsigned goal,
                                                int unsigned lim);
        logic [63:0] val;
        int unsigned f;
        int unsigned v;
        depth_sp = 0;
        if (visit_vertex(start, 0, lim, goal, val))
            return val;
        while (depth_sp > 0) begin
            f = depth_sp - 1;
            v = frm_vtx[f];
            if (frm_nxt[f] < adj_len[v] && frm_nxt[f] < dpc_pkg::MAX_NEIGHBOURS) begin
                frm_nxt[f]++;
                if (visit_vertex(adj[v][frm_nxt[f]-1], depth_sp, lim, goal, val))
                    frm_sum[f] += val;
            end else begin
                val = frm_sum[f];
                memo_cnt[v] = val;
                memo_set[v] = 1'b1;
                depth_sp = f;
                if (depth_sp > 0)
                    frm_sum[depth_sp-1] += val;
            end
        end
        return val;
    endfunction

    function automatic bit predict_beat(dpc_pkg::in_item_t it, output dpc_pkg::out_item_t res);
        int unsigned n;
        int unsigned a;
        int unsigned b;
        n = live_count();
        a = it.from_vertex;
        b = it.to_vertex;
        res = '0;
        if (it.op == dpc_pkg::OP_ADD_EDGE) begin
            if (a < n && b < n) begin
                if (adj_len[a] >= dpc_pkg::MAX_NEIGHBOURS)
                    dropped_edge = 1'b1;
                else begin
                    adj[a][adj_len[a]] = it.to_vertex;
                    adj_len[a]++;
                end
            end
            return 1'b0;
        end
        if (it.op == dpc_pkg::OP_CLEAR) begin
            foreach (adj_len[i])
                adj_len[i] = 0;
            dropped_edge = 1'b0;
            return 1'b0;
        end
        if (it.op != dpc_pkg::OP_QUERY)
            return 1'b0;
        if (a >= n || b >= n) begin
            res.status = dpc_pkg::ST_RANGE;
            return 1'b1;
        end
        foreach (memo_set[i])
            memo_set[i] = 1'b0;
        depth_flag = 1'b0;
        res.path_count = count_paths(a, b, n);
        res.status = depth_flag ? dpc_pkg::ST_DEPTH
                   : (dropped_edge ? dpc_pkg::ST_OVERFLOW : dpc_pkg::ST_OK);
        return 1'b1;
    endfunction

    task automatic send_beat(logic [1:0] op, int src, int dst, bit known,
                             logic [63:0] cnt, logic [1:0] st);
        dpc_pkg::in_item_t  it;
        dpc_pkg::out_item_t res;
        it.op = op;
        it.from_vertex = src[dpc_pkg::VTX_W-1:0];
        it.to_vertex = dst[dpc_pkg::VTX_W-1:0];
        if (!no_idle && in_held && $urandom_range(99) < 17) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 40);
        end
        in_valid <= 1'b1;
        in_data <= it;
        in_held = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (predict_beat(it, res)) begin
            if (known) begin
                res.path_count = cnt;
                res.status = st;
            end
            pending_counts.push_back(res);
        end
    endtask

    task automatic drain_and_settle();
        if (in_held) begin
            in_valid <= 1'b0;
            in_held = 1'b0;
        end
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_vertex_count(logic [10:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        vtx_count = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int pick_vertex(int unsigned n);
        if ($urandom_range(99) < 12)
            return $urandom_range(1023);
        return $urandom_range((n == 0) ? 1 : ((n > 1023) ? 1023 : n));
    endfunction

    task automatic random_phase(int items);
        int unsigned n;
        int          a;
        int          b;
        int          t;
        int          r;
        n = live_count();
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(99);
            a = pick_vertex(n);
            b = pick_vertex(n);
            if (r < 55) begin
                if ($urandom_range(99) < 80 && a > b) begin
                    t = a;
                    a = b;
                    b = t;
                end
                send_beat(dpc_pkg::OP_ADD_EDGE, a, b, 1'b0, '0, '0);
            end else if (r < 92) begin
                if (a > b && $urandom_range(1)) begin
                    t = a;
                    a = b;
                    b = t;
                end
                send_beat(dpc_pkg::OP_QUERY, a, b, 1'b0, '0, '0);
            end else if (r < 96) begin
                send_beat(dpc_pkg::OP_CLEAR, a, b, 1'b0, '0, '0);
            end else begin
                send_beat(2'd3, a, b, 1'b0, '0, '0);
            end
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= !no_idle && ($urandom_range(99) < 17);
            if (out_valid && !out_stall) begin
                if (pending_counts.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat, actual count %h status %0d",
                             $time, out_data.path_count, out_data.status);
                end else begin
                    if (out_data.path_count !== pending_counts[0].path_count) begin
                        errors++;
                        $display("%0t: path_count expected %h actual %h", $time,
                                 pending_counts[0].path_count, out_data.path_count);
                    end
                    if (out_data.status !== pending_counts[0].status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 pending_counts[0].status, out_data.status);
                    end
                    void'(pending_counts.pop_front());
                end
            end
        end
    end

    stim_row_t directed [] = '{
        '{dpc_pkg::OP_QUERY,    0,    0, 1'b1, 64'd1, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_QUERY,    5,    7, 1'b1, 64'd0, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_ADD_EDGE, 0,    1, 1'b0, 64'd0, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_ADD_EDGE, 1,    2, 1'b0, 64'd0, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_ADD_EDGE, 0,    2, 1'b0, 64'd0, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_QUERY,    0,    2, 1'b0, 64'd0, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_ADD_EDGE, 1023, 0, 1'b0, 64'd0, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_ADD_EDGE, 1023, 1, 1'b0, 64'd0, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_QUERY,    1023, 2, 1'b0, 64'd0, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_QUERY,    1023, 1023, 1'b1, 64'd1, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_QUERY,    2,    1023, 1'b1, 64'd0, dpc_pkg::ST_OK},
        '{2'd3,                 1023, 1023, 1'b0, 64'd0, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_ADD_EDGE, 2,    1,    1'b0, 64'd0, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_ADD_EDGE, 2,    3,    1'b0, 64'd0, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_QUERY,    0,    3,    1'b0, 64'd0, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_CLEAR,    0,    0,    1'b0, 64'd0, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_QUERY,    0,    2,    1'b1, 64'd0, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_ADD_EDGE, 682,  341,  1'b0, 64'd0, dpc_pkg::ST_OK},
        '{dpc_pkg::OP_QUERY,    682,  341,  1'b1, 64'd1, dpc_pkg::ST_OK}
    };

    logic [10:0] settings [] = '{11'd16, 11'd2, 11'd0, 11'd1, 11'd2047, 11'd5,
                                 11'd1024, 11'd40, 11'd3};

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = 11'd0;
        errors = 0;
        cycles = 0;
        no_idle = 1'b0;
        in_held = 1'b0;
        foreach (adj_len[i])
            adj_len[i] = 0;
        dropped_edge = 1'b0;
        vtx_count = 11'd1024;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_beat(directed[i].op, directed[i].src, directed[i].dst,
                      directed[i].known, directed[i].cnt, directed[i].st);
        drain_and_settle();

        foreach (settings[p]) begin
            write_vertex_count(settings[p]);
            no_idle = (p == 1);
            random_phase((settings[p] == 11'd2) ? 110 : 70);
            no_idle = 1'b0;
            drain_and_settle();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/dpc_pkg.sv
hdl/dpc_ram.sv
hdl/dpc_engine.sv
hdl/dag_path_counter_core.sv
test/dag_path_counter_core_test.sv
